@@ src/fk_pkg.sv @@
//------------------------------------------------------------------------------
// fk_pkg
// Shared types, constants and fixed-point helpers for the arm kinematics.
//------------------------------------------------------------------------------
`default_nettype none

package fk_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int QI            = 30;
    localparam int QW            = 36;
    localparam int MW            = 32;
    localparam int CMD_W         = 16;
    localparam int NUM_TRIG      = 14;
    localparam int SC_STAGES     = 7;
    localparam int CH_STAGES     = 6;

    typedef logic signed [QW-1:0]    t_q;
    typedef logic signed [CMD_W-1:0] t_cmd;

    typedef struct packed {
        t_cmd joint1_cmd;
        t_cmd joint2_cmd;
        t_cmd joint3_cmd;
        t_cmd joint4_cmd;
        t_cmd joint5_cmd;
        t_cmd joint6_cmd;
    } t_joints;

    typedef struct packed {
        t_cmd pos_x;
        t_cmd pos_y;
        t_cmd pos_z;
        t_cmd slide_x;
        t_cmd slide_y;
        t_cmd slide_z;
        t_cmd approach_x;
        t_cmd approach_y;
        t_cmd approach_z;
    } t_pose;

    // trig value slots
    localparam int TRIG_S1  = 0;
    localparam int TRIG_C1  = 1;
    localparam int TRIG_S2  = 2;
    localparam int TRIG_C2  = 3;
    localparam int TRIG_S3  = 4;
    localparam int TRIG_C3  = 5;
    localparam int TRIG_S4  = 6;
    localparam int TRIG_C4  = 7;
    localparam int TRIG_S5  = 8;
    localparam int TRIG_C5  = 9;
    localparam int TRIG_S6  = 10;
    localparam int TRIG_C6  = 11;
    localparam int TRIG_S23 = 12;
    localparam int TRIG_C23 = 13;

    localparam logic [MW-1:0] SIN_C9 = 32'd172272;
    localparam logic [MW-1:0] SIN_HORNER [4] = '{
        32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
    };

    localparam longint REACH_TENTHS = 587;
    localparam t_q LD1 = t_q'(((64'sd125 <<< QI) + REACH_TENTHS / 2) / REACH_TENTHS);
    localparam t_q LA2 = t_q'(((64'sd150 <<< QI) + REACH_TENTHS / 2) / REACH_TENTHS);
    localparam t_q LD4 = t_q'(((64'sd192 <<< QI) + REACH_TENTHS / 2) / REACH_TENTHS);
    localparam t_q LD6 = t_q'(((64'sd120 <<< QI) + REACH_TENTHS / 2) / REACH_TENTHS);

    localparam logic [2*MW-1:0] HALF_I = 64'(1) << (QI - 1);

    // q30 product, rounded half away from zero
    function automatic t_q mq(input t_q a, input t_q b);
        logic [QW-1:0]   ua;
        logic [QW-1:0]   ub;
        logic [MW-1:0]   ma;
        logic [MW-1:0]   mb;
        logic [2*MW-1:0] p;
        logic [QW-1:0]   r;
        ua = a[QW-1] ? -a : a;
        ub = b[QW-1] ? -b : b;
        ma = ua[MW-1:0];
        mb = ub[MW-1:0];
        p  = ma * mb + HALF_I;
        r  = QW'(p[2*MW-1:QI]);
        return (a[QW-1] ^ b[QW-1]) ? -r : r;
    endfunction

endpackage

`default_nettype wire

@@ src/fk_stream_if.sv @@
//------------------------------------------------------------------------------
// fk_stream_if
// Valid/ready channel carrying one item of type T.
//------------------------------------------------------------------------------
`default_nettype none

interface fk_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/fk_sincos.sv @@
//------------------------------------------------------------------------------
// fk_sincos
// Pipelined sine of a quarter-turn phase, polynomial evaluated in q30.
//------------------------------------------------------------------------------
`default_nettype none

module fk_sincos #(
    parameter int FRAC_BITS = fk_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic [fk_pkg::SC_STAGES-1:0]   i_en,
    input  logic [FRAC_BITS+1:0]           i_phase,
    output fk_pkg::t_q                     o_val
);
    import fk_pkg::*;

    localparam int PW = FRAC_BITS + 2;
    localparam int XW = QI + 1;
    localparam int NH = 4;
    localparam logic [FRAC_BITS:0] ONE_R = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [XW+1:0]      ONE_M = {3'b001, {QI{1'b0}}};

    logic [1:0]       w_quad;
    logic [FRAC_BITS:0] w_r;
    logic [XW-1:0]    r_x1;
    logic             r_neg1;
    logic [2*XW-1:0]  w_sq;
    logic [XW-1:0]    r_x2;
    logic [XW-1:0]    r_sq2;
    logic             r_neg2;
    logic [XW-1:0]    r_hx  [NH];
    logic [XW-1:0]    r_hx2 [NH];
    logic [MW-1:0]    r_ht  [NH];
    logic             r_hneg[NH];
    logic [XW+MW-1:0] w_y;
    logic [XW+1:0]    w_mag;
    t_q               r_val;

    always_comb begin
        w_quad = i_phase[PW-1:PW-2];
        w_r    = {1'b0, i_phase[FRAC_BITS-1:0]};
        if (w_quad[0]) begin
            w_r = ONE_R - w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x1   <= {w_r, {(QI-FRAC_BITS){1'b0}}};
            r_neg1 <= w_quad[1];
        end
    end

    assign w_sq = r_x1 * r_x1;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x2   <= r_x1;
            r_sq2  <= w_sq[2*QI:QI];
            r_neg2 <= r_neg1;
        end
    end

    for (genvar h = 0; h < NH; h++) begin : g_horner
        logic [XW-1:0]    w_px;
        logic [XW-1:0]    w_px2;
        logic [MW-1:0]    w_pt;
        logic             w_pneg;
        logic [XW+MW-1:0] w_prod;

        if (h == 0) begin : g_first
            assign w_px   = r_x2;
            assign w_px2  = r_sq2;
            assign w_pt   = SIN_C9;
            assign w_pneg = r_neg2;
        end else begin : g_next
            assign w_px   = r_hx[h-1];
            assign w_px2  = r_hx2[h-1];
            assign w_pt   = r_ht[h-1];
            assign w_pneg = r_hneg[h-1];
        end

        assign w_prod = w_px2 * w_pt;

        always_ff @(posedge i_clk) begin
            if (i_en[2+h]) begin
                r_hx[h]   <= w_px;
                r_hx2[h]  <= w_px2;
                r_ht[h]   <= SIN_HORNER[h] - w_prod[QI+MW-1:QI];
                r_hneg[h] <= w_pneg;
            end
        end
    end

    always_comb begin
        w_y   = r_hx[NH-1] * r_ht[NH-1];
        w_mag = w_y[XW+MW-1:QI];
        if (w_mag > ONE_M) begin
            w_mag = ONE_M;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[SC_STAGES-1]) begin
            r_val <= r_hneg[NH-1] ? -t_q'(w_mag) : t_q'(w_mag);
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

@@ src/fk_chain.sv @@
//------------------------------------------------------------------------------
// fk_chain
// Kinematic product chain: five q30 product stages and an output stage.
//------------------------------------------------------------------------------
`default_nettype none

module fk_chain #(
    parameter int FRAC_BITS = fk_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic [fk_pkg::CH_STAGES-1:0] i_en,
    input  fk_pkg::t_q                   i_trig [fk_pkg::NUM_TRIG],
    output fk_pkg::t_pose                o_pose
);
    import fk_pkg::*;

    localparam int SH = QI - FRAC_BITS;
    localparam logic [QW-1:0] RND     = QW'(1) << (SH - 1);
    localparam logic [QW-1:0] ONE_OUT = QW'(1) << FRAC_BITS;

    function automatic t_cmd to_out(input t_q v);
        logic [QW-1:0] mag;
        logic [QW-1:0] res;
        mag = v[QW-1] ? -v : v;
        mag = (mag + RND) >> SH;
        if (mag > ONE_OUT) begin
            mag = ONE_OUT;
        end
        res = v[QW-1] ? -mag : mag;
        return res[CMD_W-1:0];
    endfunction

    // stage 1
    t_q r_trig1 [NUM_TRIG];
    t_q r_a1, r_b1, r_c1, r_d1, r_e1, r_f1, r_g1, r_i1, r_j1, r_k1, r_l1, r_m1;
    t_q r_n1, r_o1, r_p1, r_q1, r_r1, r_rch1, r_s1, r_t1, r_u1, r_w1, r_x1;
    t_q r_z1, r_aa1;
    // stage 2
    t_q r_trig2 [NUM_TRIG];
    t_q w_reach;
    t_q r_sxa2, r_sxb2, r_sxc2, r_sya2, r_syb2, r_syc2, r_sza2, r_szb2;
    t_q r_axa2, r_axb2, r_aya2, r_ayb2, r_aza2, r_pxa2, r_pxb2, r_pxc2;
    t_q r_pya2, r_pyd2, r_pyh2, r_pyi2, r_pza2, r_pzb2;
    t_q r_a2, r_e2, r_f2, r_i2, r_m2, r_o2, r_p2, r_q2, r_t2, r_w2, r_z2;
    // stage 3
    t_q r_trig3 [NUM_TRIG];
    t_q r_sxd3, r_sxe3, r_syd3, r_sye3, r_szc3, r_axc3, r_ayc3, r_pxd3, r_pxe3;
    t_q r_pyb3, r_pye3, r_pyj3, r_pzc3;
    t_q r_sxb3, r_syb3, r_sza3, r_axa3, r_aya3, r_aza3, r_q3, r_pxb3, r_t3;
    t_q r_p3, r_pyh3, r_w3, r_pza3, r_z3;
    // stage 4
    t_q r_sxf4, r_syf4, r_pxf4, r_pyc4, r_pyf4, r_pyk4;
    t_q r_sz4, r_ax4, r_ay4, r_az4, r_pz4, r_sxd4, r_syd4, r_pxd4, r_s5_4;
    // stage 5
    t_q r_pyg5, r_sx5, r_sy5, r_px5, r_pyc5, r_pyk5, r_sz5, r_ax5, r_ay5, r_az5, r_pz5;
    // output
    t_pose r_pose;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_trig1 <= i_trig;
            r_a1    <= mq(i_trig[TRIG_C4], i_trig[TRIG_S1]);
            r_b1    <= mq(i_trig[TRIG_C1], i_trig[TRIG_C23]);
            r_c1    <= mq(i_trig[TRIG_C5], i_trig[TRIG_S1]);
            r_d1    <= mq(i_trig[TRIG_C23], i_trig[TRIG_C4]);
            r_e1    <= mq(i_trig[TRIG_S23], i_trig[TRIG_S5]);
            r_f1    <= mq(i_trig[TRIG_C4], i_trig[TRIG_C6]);
            r_g1    <= mq(i_trig[TRIG_C5], i_trig[TRIG_S4]);
            r_i1    <= mq(i_trig[TRIG_C6], i_trig[TRIG_S4]);
            r_j1    <= mq(i_trig[TRIG_C4], i_trig[TRIG_S5]);
            r_k1    <= mq(i_trig[TRIG_C6], i_trig[TRIG_S23]);
            r_l1    <= mq(i_trig[TRIG_C4], i_trig[TRIG_C5]);
            r_m1    <= mq(i_trig[TRIG_C23], i_trig[TRIG_S5]);
            r_n1    <= mq(i_trig[TRIG_S1], i_trig[TRIG_S4]);
            r_o1    <= mq(i_trig[TRIG_C5], i_trig[TRIG_S23]);
            r_p1    <= mq(i_trig[TRIG_C1], i_trig[TRIG_S4]);
            r_q1    <= mq(i_trig[TRIG_C23], i_trig[TRIG_C5]);
            r_r1    <= mq(i_trig[TRIG_C4], i_trig[TRIG_S23]);
            r_rch1  <= mq(LD6, i_trig[TRIG_C5]);
            r_s1    <= mq(LD6, i_trig[TRIG_S1]);
            r_t1    <= mq(LA2, i_trig[TRIG_C2]);
            r_u1    <= mq(LD6, i_trig[TRIG_C23]);
            r_w1    <= mq(i_trig[TRIG_C2], i_trig[TRIG_S1]);
            r_x1    <= mq(LD6, i_trig[TRIG_C3]);
            r_z1    <= mq(LA2, i_trig[TRIG_S2]);
            r_aa1   <= mq(LD6, i_trig[TRIG_C4]);
        end
    end

    assign w_reach = LD4 + r_rch1;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_trig2 <= r_trig1;
            r_sxa2  <= mq(r_b1, r_trig1[TRIG_S4]);
            r_sxb2  <= mq(r_c1, r_trig1[TRIG_S4]);
            r_sxc2  <= mq(r_d1, r_trig1[TRIG_C5]);
            r_sya2  <= mq(r_g1, r_trig1[TRIG_S6]);
            r_syb2  <= mq(r_e1, r_trig1[TRIG_S6]);
            r_syc2  <= mq(r_j1, r_trig1[TRIG_S6]);
            r_sza2  <= mq(r_k1, r_trig1[TRIG_S4]);
            r_szb2  <= mq(r_l1, r_trig1[TRIG_S23]);
            r_axa2  <= mq(r_n1, r_trig1[TRIG_S5]);
            r_axb2  <= mq(r_d1, r_trig1[TRIG_S5]);
            r_aya2  <= mq(r_c1, r_trig1[TRIG_S23]);
            r_ayb2  <= mq(r_d1, r_trig1[TRIG_S1]);
            r_aza2  <= mq(r_r1, r_trig1[TRIG_S5]);
            r_pxa2  <= mq(r_s1, r_trig1[TRIG_S4]);
            r_pxb2  <= mq(w_reach, r_trig1[TRIG_S23]);
            r_pxc2  <= mq(r_u1, r_trig1[TRIG_C4]);
            r_pya2  <= mq(r_trig1[TRIG_C3], w_reach);
            r_pyd2  <= mq(r_a1, r_trig1[TRIG_S2]);
            r_pyh2  <= mq(w_reach, r_trig1[TRIG_S3]);
            r_pyi2  <= mq(r_x1, r_trig1[TRIG_C4]);
            r_pza2  <= mq(r_trig1[TRIG_C23], w_reach);
            r_pzb2  <= mq(r_aa1, r_trig1[TRIG_S23]);
            r_a2    <= r_a1;
            r_e2    <= r_e1;
            r_f2    <= r_f1;
            r_i2    <= r_i1;
            r_m2    <= r_m1;
            r_o2    <= r_o1;
            r_p2    <= r_p1;
            r_q2    <= r_q1;
            r_t2    <= r_t1;
            r_w2    <= r_w1;
            r_z2    <= r_z1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_trig3 <= r_trig2;
            r_sxd3  <= mq(r_trig2[TRIG_C6], r_a2 - r_sxa2);
            r_sxe3  <= mq(r_trig2[TRIG_C1], r_sxc2 - r_e2);
            r_syd3  <= mq(r_trig2[TRIG_C1], r_sya2 - r_f2);
            r_sye3  <= mq(r_trig2[TRIG_C23], r_i2 + r_syc2);
            r_szc3  <= mq(r_szb2 + r_m2, r_trig2[TRIG_S6]);
            r_axc3  <= mq(r_trig2[TRIG_C1], r_o2 + r_axb2);
            r_ayc3  <= mq(r_ayb2 - r_p2, r_trig2[TRIG_S5]);
            r_pxd3  <= mq(r_pxa2, r_trig2[TRIG_S5]);
            r_pxe3  <= mq(r_pxc2, r_trig2[TRIG_S5]);
            r_pyb3  <= mq(r_pya2, r_trig2[TRIG_S1]);
            r_pye3  <= mq(r_pyd2, r_trig2[TRIG_S3]);
            r_pyj3  <= mq(r_pyi2, r_trig2[TRIG_S5]);
            r_pzc3  <= mq(r_pzb2, r_trig2[TRIG_S5]);
            r_sxb3  <= r_sxb2;
            r_syb3  <= r_syb2;
            r_sza3  <= r_sza2;
            r_axa3  <= r_axa2;
            r_aya3  <= r_aya2;
            r_aza3  <= r_aza2;
            r_q3    <= r_q2;
            r_pxb3  <= r_pxb2;
            r_t3    <= r_t2;
            r_p3    <= r_p2;
            r_pyh3  <= r_pyh2;
            r_w3    <= r_w2;
            r_pza3  <= r_pza2;
            r_z3    <= r_z2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_sxf4 <= mq(r_sxb3 + r_sxe3, r_trig3[TRIG_S6]);
            r_syf4 <= mq(r_trig3[TRIG_S1], r_sye3 - r_syb3);
            r_pxf4 <= mq(r_trig3[TRIG_C1], r_t3 + r_pxb3 + r_pxe3);
            r_pyc4 <= mq(r_pyb3, r_trig3[TRIG_S2]);
            r_pyf4 <= mq(LD6, r_pye3 + r_p3);
            r_pyk4 <= mq(r_w3, LA2 + r_pyh3 + r_pyj3);
            r_sz4  <= -r_sza3 - r_szc3;
            r_ax4  <= r_axa3 + r_axc3;
            r_ay4  <= r_aya3 + r_ayc3;
            r_az4  <= r_aza3 - r_q3;
            r_pz4  <= LD1 - r_pza3 + r_z3 + r_pzc3;
            r_sxd4 <= r_sxd3;
            r_syd4 <= r_syd3;
            r_pxd4 <= r_pxd3;
            r_s5_4 <= r_trig3[TRIG_S5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_pyg5 <= mq(r_pyf4, r_s5_4);
            r_sx5  <= r_sxd4 - r_sxf4;
            r_sy5  <= r_syd4 - r_syf4;
            r_px5  <= r_pxd4 + r_pxf4;
            r_pyc5 <= r_pyc4;
            r_pyk5 <= r_pyk4;
            r_sz5  <= r_sz4;
            r_ax5  <= r_ax4;
            r_ay5  <= r_ay4;
            r_az5  <= r_az4;
            r_pz5  <= r_pz4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_pose.pos_x      <= to_out(r_px5);
            r_pose.pos_y      <= to_out(r_pyc5 - r_pyg5 + r_pyk5);
            r_pose.pos_z      <= to_out(r_pz5);
            r_pose.slide_x    <= to_out(r_sx5);
            r_pose.slide_y    <= to_out(r_sy5);
            r_pose.slide_z    <= to_out(r_sz5);
            r_pose.approach_x <= to_out(r_ax5);
            r_pose.approach_y <= to_out(r_ay5);
            r_pose.approach_z <= to_out(r_az5);
        end
    end

    assign o_pose = r_pose;

endmodule

`default_nettype wire

@@ src/six_axis_arm_forward_kinematics.sv @@
//------------------------------------------------------------------------------
// six_axis_arm_forward_kinematics
// Joint commands to normalized gripper position and s/a orientation vectors.
//------------------------------------------------------------------------------
//  channel   dir  payload    handshake
//  i_cmd     in   t_joints   valid/ready
//  o_pose    out  t_pose     valid/ready
//
//  one item per cycle sustained while o_pose is ready; stages: phase stage, 7 sine
//  stages, 5 product stages and the output register
//  every stage holds a valid bit and loads when empty or when the stage
//  after it moves, so bubbles are squeezed out during a stall
//  synchronous active-low reset clears the valid bits only
//------------------------------------------------------------------------------
`default_nettype none

module six_axis_arm_forward_kinematics #(
    parameter int FRAC_BITS = fk_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fk_stream_if.sink    i_cmd,
    fk_stream_if.source  o_pose
);
    import fk_pkg::*;

    localparam int PW = FRAC_BITS + 2;
    localparam int NS = 1 + SC_STAGES + CH_STAGES;
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      n_vld;
    logic [NS-1:0]      w_en;
    logic signed [31:0] w_u [6];
    logic signed [31:0] w_ph [NUM_TRIG];
    logic [PW-1:0]      r_ph [NUM_TRIG];
    t_q                 w_trig [NUM_TRIG];
    t_pose              w_pose;

    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || o_pose.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_cmd.valid : r_vld[0];
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_cmd.ready  = w_en[0];
    assign o_pose.valid = r_vld[NS-1];
    assign o_pose.data  = w_pose;

    // joint phases in quarter turns
    always_comb begin
        w_u[0] = 32'(i_cmd.data.joint1_cmd);
        w_u[1] = 32'(i_cmd.data.joint2_cmd);
        w_u[2] = 32'(i_cmd.data.joint3_cmd);
        w_u[3] = 32'(i_cmd.data.joint4_cmd);
        w_u[4] = 32'(i_cmd.data.joint5_cmd);
        w_u[5] = 32'(i_cmd.data.joint6_cmd);
        w_ph[TRIG_S1]  = w_u[0] + ONE_Q;
        w_ph[TRIG_C1]  = w_u[0] + ONE_Q + ONE_Q;
        w_ph[TRIG_S2]  = w_u[1] + ONE_Q;
        w_ph[TRIG_C2]  = w_u[1] + ONE_Q + ONE_Q;
        w_ph[TRIG_S3]  = -w_u[2];
        w_ph[TRIG_C3]  = ONE_Q - w_u[2];
        w_ph[TRIG_S4]  = w_u[3] + w_u[3];
        w_ph[TRIG_C4]  = w_u[3] + w_u[3] + ONE_Q;
        w_ph[TRIG_S5]  = w_u[4] + ONE_Q;
        w_ph[TRIG_C5]  = w_u[4] + ONE_Q + ONE_Q;
        w_ph[TRIG_S6]  = w_u[5] + w_u[5];
        w_ph[TRIG_C6]  = w_u[5] + w_u[5] + ONE_Q;
        w_ph[TRIG_S23] = w_u[1] + ONE_Q - w_u[2];
        w_ph[TRIG_C23] = w_u[1] + ONE_Q - w_u[2] + ONE_Q;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int k = 0; k < NUM_TRIG; k++) begin
                r_ph[k] <= w_ph[k][PW-1:0];
            end
        end
    end

    for (genvar g = 0; g < NUM_TRIG; g++) begin : g_trig
        fk_sincos #(
            .FRAC_BITS (FRAC_BITS)
        ) u_sincos (
            .i_clk   (i_clk),
            .i_en    (w_en[SC_STAGES:1]),
            .i_phase (r_ph[g]),
            .o_val   (w_trig[g])
        );
    end

    fk_chain #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chain (
        .i_clk  (i_clk),
        .i_en   (w_en[NS-1:SC_STAGES+1]),
        .i_trig (w_trig),
        .o_pose (w_pose)
    );

endmodule

`default_nettype wire

@@ src/fk_checker.sv @@
//------------------------------------------------------------------------------
// fk_checker
// Port-level checks for the arm kinematics pipeline, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module fk_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input fk_pkg::t_pose i_out_data
);
    import fk_pkg::*;

    localparam int DEPTH = 1 + SC_STAGES + CH_STAGES;

    // held result keeps its value
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output item changed while stalled");

    // an empty output register means the whole pipe can move
    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // reset empties the pipe
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // after reset, the first item cannot come out sooner than the pipe depth
    a_depth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid [*DEPTH])
        else $error("item left the pipe too early");

endmodule

bind six_axis_arm_forward_kinematics fk_checker u_fk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_pose.valid),
    .i_out_ready (o_pose.ready),
    .i_out_data  (o_pose.data)
);

`default_nettype wire

@@ sim/six_axis_arm_forward_kinematics_tb.sv @@
//------------------------------------------------------------------------------
// six_axis_arm_forward_kinematics_tb
// Drives joint command items into the kinematics pipeline with random gaps and
// random output stalls. A bit-accurate fixed-point predictor computes each
// expected pose, and every pose item is checked field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module six_axis_arm_forward_kinematics_tb;

    import fk_pkg::*;

    localparam int  RST_CYCLES = 11;
    localparam int  DRAIN_WAIT = 40;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  MAX_REPORTS = 10;
    localparam int  NUM_FIELDS = 9;
    localparam longint HALF_Q30 = 64'sd1 <<< 29;
    localparam longint ONE_Q30 = 64'sd1 <<< 30;
    localparam longint ONE_CMD = 64'sd16384;

    logic i_clk;
    logic i_rst_n;

    fk_stream_if #(.T(t_joints)) cmd_if ();
    fk_stream_if #(.T(t_pose))   pose_if ();

    six_axis_arm_forward_kinematics dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pose  (pose_if)
    );

    t_joints pending_cmds[$];
    t_pose   expected_poses[$];
    int      mismatches;
    int      cycle_count;
    int      send_gap;
    int      stall_left;
    logic    cmd_taken;
    logic    burst_mode;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // rounded q30 product
    function automatic longint q30_mul(input longint a, input longint b);
        bit [63:0] ua;
        bit [63:0] ub;
        longint    r;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        r  = longint'((ua * ub + HALF_Q30) >> 30);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint link_len(input longint tenths);
        return ((tenths <<< 30) + 293) / 587;
    endfunction

    function automatic bit [63:0] sine_poly(input bit [63:0] x);
        bit [63:0] x2;
        bit [63:0] t;
        x2 = (x * x) >> 30;
        t  = 64'd172272;
        t  = 64'd5026995 - ((x2 * t) >> 30);
        t  = 64'd85569306 - ((x2 * t) >> 30);
        t  = 64'd693598668 - ((x2 * t) >> 30);
        t  = 64'd1686629713 - ((x2 * t) >> 30);
        return (x * t) >> 30;
    endfunction

    function automatic longint phase_sin(input bit [63:0] ph);
        bit [63:0] p;
        bit [1:0]  quad;
        bit [63:0] r;
        bit [63:0] mag;
        p    = ph & 64'hFFFF;
        quad = p[15:14];
        r    = p & 64'h3FFF;
        if (quad[0]) r = 64'd16384 - r;
        mag = sine_poly(r << 16);
        if (mag > 64'(ONE_Q30)) mag = 64'(ONE_Q30);
        return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint phase_cos(input bit [63:0] ph);
        return phase_sin(ph + 64'd16384);
    endfunction

    function automatic t_cmd to_cmd_fmt(input longint v);
        bit [63:0] mag;
        longint    r;
        mag = v < 0 ? -v : v;
        mag = (mag + 64'd32768) >> 16;
        if (mag > 64'd16384) mag = 64'd16384;
        r = v < 0 ? -longint'(mag) : longint'(mag);
        return t_cmd'(r[15:0]);
    endfunction

    function automatic t_pose predict_pose(input t_joints j);
        longint    u1, u2, u3, u4, u5, u6;
        bit [63:0] p1, p2, p3, p4, p5, p6, p23;
        longint    s1, c1, s2, c2, s3, c3, s4, c4, s5, c5, s6, c6, s23, c23;
        longint    d1, a2, d4, d6, reach;
        longint    sx, sy, sz, ax, ay, az, px, py, pz;
        t_pose     res;
        u1 = longint'(j.joint1_cmd); u2 = longint'(j.joint2_cmd);
        u3 = longint'(j.joint3_cmd); u4 = longint'(j.joint4_cmd);
        u5 = longint'(j.joint5_cmd); u6 = longint'(j.joint6_cmd);
        p1 = u1 + ONE_CMD; p2 = u2 + ONE_CMD; p3 = -u3;
        p4 = 2 * u4;       p5 = u5 + ONE_CMD; p6 = 2 * u6;
        p23 = p2 + p3;
        s1 = phase_sin(p1); c1 = phase_cos(p1); s2 = phase_sin(p2); c2 = phase_cos(p2);
        s3 = phase_sin(p3); c3 = phase_cos(p3); s4 = phase_sin(p4); c4 = phase_cos(p4);
        s5 = phase_sin(p5); c5 = phase_cos(p5); s6 = phase_sin(p6); c6 = phase_cos(p6);
        s23 = phase_sin(p23); c23 = phase_cos(p23);
        d1 = link_len(125); a2 = link_len(150); d4 = link_len(192); d6 = link_len(120);
        reach = d4 + q30_mul(d6, c5);

        sx = q30_mul(c6, q30_mul(c4, s1) - q30_mul(q30_mul(c1, c23), s4))
           - q30_mul(q30_mul(q30_mul(c5, s1), s4)
                     + q30_mul(c1, q30_mul(q30_mul(c23, c4), c5) - q30_mul(s23, s5)), s6);
        sy = q30_mul(c1, q30_mul(-c4, c6) + q30_mul(q30_mul(c5, s4), s6))
           - q30_mul(s1, q30_mul(q30_mul(-s23, s5), s6)
                     + q30_mul(c23, q30_mul(c6, s4) + q30_mul(q30_mul(c4, s5), s6)));
        sz = q30_mul(q30_mul(-c6, s23), s4)
           - q30_mul(q30_mul(q30_mul(c4, c5), s23) + q30_mul(c23, s5), s6);
        ax = q30_mul(q30_mul(s1, s4), s5)
           + q30_mul(c1, q30_mul(c5, s23) + q30_mul(q30_mul(c23, c4), s5));
        ay = q30_mul(q30_mul(c5, s1), s23)
           + q30_mul(q30_mul(q30_mul(c23, c4), s1) - q30_mul(c1, s4), s5);
        az = q30_mul(-c23, c5) + q30_mul(q30_mul(c4, s23), s5);

        px = q30_mul(q30_mul(q30_mul(d6, s1), s4), s5)
           + q30_mul(c1, q30_mul(a2, c2) + q30_mul(reach, s23)
                     + q30_mul(q30_mul(q30_mul(d6, c23), c4), s5));
        py = q30_mul(q30_mul(q30_mul(c3, reach), s1), s2)
           - q30_mul(q30_mul(d6, q30_mul(q30_mul(q30_mul(c4, s1), s2), s3)
                     + q30_mul(c1, s4)), s5)
           + q30_mul(q30_mul(c2, s1), a2 + q30_mul(reach, s3)
                     + q30_mul(q30_mul(q30_mul(d6, c3), c4), s5));
        pz = d1 - q30_mul(c23, reach) + q30_mul(a2, s2)
           + q30_mul(q30_mul(q30_mul(d6, c4), s23), s5);

        res.pos_x      = to_cmd_fmt(px);
        res.pos_y      = to_cmd_fmt(py);
        res.pos_z      = to_cmd_fmt(pz);
        res.slide_x    = to_cmd_fmt(sx);
        res.slide_y    = to_cmd_fmt(sy);
        res.slide_z    = to_cmd_fmt(sz);
        res.approach_x = to_cmd_fmt(ax);
        res.approach_y = to_cmd_fmt(ay);
        res.approach_z = to_cmd_fmt(az);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_cmd rand_cmd();
        if ($urandom_range(0, 9) < 2) return t_cmd'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
                0: return t_cmd'(-16384);
                1: return t_cmd'(16384);
                2: return t_cmd'(0);
                3: return t_cmd'(8192);
                default: return t_cmd'(-8192);
            endcase
        end
        return t_cmd'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic t_joints make_joints(input int a, input int b, input int c,
                                            input int d, input int e, input int f);
        t_joints j;
        j.joint1_cmd = t_cmd'(a); j.joint2_cmd = t_cmd'(b); j.joint3_cmd = t_cmd'(c);
        j.joint4_cmd = t_cmd'(d); j.joint5_cmd = t_cmd'(e); j.joint6_cmd = t_cmd'(f);
        return j;
    endfunction

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (send_gap > 0) begin
                send_gap     <= send_gap - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cmd_if.data  <= pending_cmds.pop_front();
                cmd_if.valid <= 1'b1;
                send_gap     <= pick_gap();
                if ($urandom_range(0, 79) == 0) burst_mode <= ~burst_mode;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            pose_if.ready <= 1'b0;
        end else if (!burst_mode && $urandom_range(0, 99) < 25) begin
            stall_left    <= pick_gap();
            pose_if.ready <= 1'b0;
        end else begin
            pose_if.ready <= 1'b1;
        end
    end

    // acceptance and checking
    always @(posedge i_clk) begin
        t_pose      want;
        logic [143:0] want_v;
        logic [143:0] got_v;
        bit         bad;
        cycle_count <= cycle_count + 1;
        cmd_taken   <= i_rst_n && cmd_if.valid && cmd_if.ready;
        if (i_rst_n && cmd_if.valid && cmd_if.ready)
            expected_poses.push_back(predict_pose(cmd_if.data));
        if (i_rst_n && pose_if.valid && pose_if.ready) begin
            got_v = pose_if.data;
            if (expected_poses.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_REPORTS)
                    $display("unexpected pose item %h", got_v);
            end else begin
                want   = expected_poses.pop_front();
                want_v = want;
                bad    = 1'b0;
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    if (want_v[143 - 16*k -: 16] !== got_v[143 - 16*k -: 16]) bad = 1'b1;
                end
                if (bad) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("pose mismatch: expected %h actual %h", want_v, got_v);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int vals[6];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        pose_if.ready = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        send_gap      = 0;
        stall_left    = 0;
        cmd_taken     = 1'b0;
        burst_mode    = 1'b0;

        // directed poses
        pending_cmds.push_back(make_joints(0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_joints(16384, 16384, 16384, 16384, 16384, 16384));
        pending_cmds.push_back(make_joints(-16384, -16384, -16384, -16384, -16384, -16384));
        pending_cmds.push_back(make_joints(32767, 32767, 32767, 32767, 32767, 32767));
        pending_cmds.push_back(make_joints(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_cmds.push_back(make_joints(-1, -1, -1, -1, -1, -1));
        pending_cmds.push_back(make_joints(1, -1, 1, -1, 1, -1));
        pending_cmds.push_back(make_joints(16384, -16384, 16384, -16384, 16384, -16384));
        pending_cmds.push_back(make_joints(-16384, 16384, -16384, 16384, -16384, 16384));
        pending_cmds.push_back(make_joints(0, 16384, 0, 0, 16384, 0));
        pending_cmds.push_back(make_joints(0, -16384, 16384, 0, -16384, 0));
        pending_cmds.push_back(make_joints(8192, 8192, 8192, 8192, 8192, 8192));
        pending_cmds.push_back(make_joints(-8192, 4096, -4096, 12288, -12288, 2048));
        pending_cmds.push_back(make_joints(21845, -21845, 30000, -30000, 20000, -20000));
        pending_cmds.push_back(make_joints(16383, 16385, -16383, -16385, 1, 0));
        pending_cmds.push_back(make_joints(0, 0, 32767, 0, 0, -32768));

        // random poses
        repeat (650) begin
            for (int k = 0; k < 6; k++) vals[k] = rand_cmd();
            pending_cmds.push_back(make_joints(vals[0], vals[1], vals[2],
                                               vals[3], vals[4], vals[5]));
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_cmds.size() > 0 || cmd_if.valid || expected_poses.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ six_axis_arm_forward_kinematics.f @@
src/fk_pkg.sv
src/fk_stream_if.sv
src/fk_sincos.sv
src/fk_chain.sv
src/six_axis_arm_forward_kinematics.sv
src/fk_checker.sv
sim/six_axis_arm_forward_kinematics_tb.sv
